FILE: hdl/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants of the sync/length/checksum deframer: register
// indexes, result status codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package slcd_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_SYNC_VALUE = 8'd0;
    localparam logic [7:0] CFG_MAX_LENGTH = 8'd1;

    // Reset values of the configuration registers
    localparam logic [7:0] SYNC_RESET    = 8'hEA;
    localparam logic [4:0] MAXLEN_RESET  = 5'd16;

    // Most results one frame may produce
    localparam int MAX_RESULTS = 16;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LEN_ERR = 2'd1;
    localparam logic [1:0] ST_SUM_ERR = 2'd2;

    // Commands from controller to datapath
    typedef struct packed {
        logic ld_sync;      // sync byte taken: seed checksum
        logic ld_opcode;    // opcode byte taken
        logic ld_length;    // accepted length byte taken
        logic wr_byte;      // payload byte taken
        logic put_len_err;  // load length-error result
        logic put_sum_err;  // load checksum-error result
        logic put_empty;    // load empty-frame result
        logic start_emit;   // begin payload emission
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic sync_match;
        logic len_over;
        logic len_zero;
        logic count_done;
        logic sum_match;
        logic held_zero;
        logic out_free;
        logic emit_final;
    } t_dp_stat;

endpackage

FILE: hdl/slcd_ram.sv
// ----------------------------------------------------------------------------
// slcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module slcd_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/slcd_ctrl.sv
// ----------------------------------------------------------------------------
// slcd_ctrl
// Frame phase state machine: decodes each accepted byte into datapath
// commands and holds input off while payload bytes are emitted.
// ----------------------------------------------------------------------------
module slcd_ctrl
    import slcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_OPCODE,
        S_LENGTH,
        S_PAYLOAD,
        S_CHECK,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_in_ready = (r_state != S_EMIT) && i_stat.out_free;
    assign take       = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_HUNT: begin
                if (take && i_stat.sync_match) begin
                    o_cmd.ld_sync = 1'b1;
                    n_state       = S_OPCODE;
                end
            end
            S_OPCODE: begin
                if (take) begin
                    o_cmd.ld_opcode = 1'b1;
                    n_state         = S_LENGTH;
                end
            end
            S_LENGTH: begin
                if (take) begin
                    if (i_stat.len_over) begin
                        o_cmd.put_len_err = 1'b1;
                        n_state           = S_HUNT;
                    end else begin
                        o_cmd.ld_length = 1'b1;
                        n_state         = i_stat.len_zero ? S_CHECK : S_PAYLOAD;
                    end
                end
            end
            S_PAYLOAD: begin
                if (take) begin
                    o_cmd.wr_byte = 1'b1;
                    if (i_stat.count_done) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (take) begin
                    n_state = S_HUNT;
                    if (!i_stat.sum_match) begin
                        o_cmd.put_sum_err = 1'b1;
                    end else if (i_stat.held_zero) begin
                        o_cmd.put_empty = 1'b1;
                    end else begin
                        o_cmd.start_emit = 1'b1;
                        n_state          = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.emit_final) begin
                    n_state = S_HUNT;
                end
            end
            default: begin
                n_state = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hdl/slcd_datapath.sv
// ----------------------------------------------------------------------------
// slcd_datapath
// Configuration registers, frame fields, running checksum, payload store
// and the result output register.
// ----------------------------------------------------------------------------
module slcd_datapath
    import slcd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic [7:0] i_rx_byte,
    input  t_dp_cmd    i_cmd,
    output t_dp_stat   o_stat,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_frame_opcode,
    output logic [7:0] o_frame_length,
    output logic [7:0] o_payload_byte,
    output logic [3:0] o_payload_index,
    output logic [1:0] o_status,
    output logic       o_last
);

    localparam int ADDR_W = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam logic [4:0] LIM_CAP =
        5'((PAYLOAD_DEPTH < MAX_RESULTS) ? PAYLOAD_DEPTH : MAX_RESULTS);

    logic [7:0] r_sync_value;
    logic [4:0] r_max_length;
    logic [7:0] r_opcode;
    logic [4:0] r_held_length;
    logic [4:0] r_byte_count;
    logic [7:0] r_check;

    logic       r_out_valid;
    logic [7:0] r_out_opcode;
    logic [7:0] r_out_length;
    logic [1:0] r_out_status;
    logic       r_last;
    logic       r_from_ram;
    logic [3:0] r_idx;
    logic [3:0] n_idx;

    logic [4:0] limit;
    logic       out_take;
    logic       load_any;
    logic [7:0] rd_data;

    assign limit    = (r_max_length > LIM_CAP) ? LIM_CAP : r_max_length;
    assign out_take = r_out_valid && i_out_ready;
    assign load_any = i_cmd.put_len_err || i_cmd.put_sum_err || i_cmd.put_empty
                      || i_cmd.start_emit;

    always_comb begin
        o_stat.sync_match = (i_rx_byte == r_sync_value);
        o_stat.len_over   = (i_rx_byte > {3'b000, limit});
        o_stat.len_zero   = (i_rx_byte == 8'd0);
        o_stat.count_done = ((r_byte_count + 5'd1) >= r_held_length);
        o_stat.sum_match  = (i_rx_byte == r_check);
        o_stat.held_zero  = (r_held_length == 5'd0);
        o_stat.out_free   = !r_out_valid || i_out_ready;
        o_stat.emit_final = out_take && r_last;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_RESET;
            r_max_length <= MAXLEN_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SYNC_VALUE) begin
                r_sync_value <= i_cfg_data;
            end else if (i_cfg_index == CFG_MAX_LENGTH) begin
                r_max_length <= i_cfg_data[4:0];
            end
        end
    end

    // Frame fields and running checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opcode      <= 8'd0;
            r_held_length <= 5'd0;
            r_byte_count  <= 5'd0;
            r_check       <= 8'hFF;
        end else begin
            if (i_cmd.ld_sync) begin
                r_check <= 8'hFF - i_rx_byte;
            end
            if (i_cmd.ld_opcode) begin
                r_opcode <= i_rx_byte;
                r_check  <= r_check - i_rx_byte;
            end
            if (i_cmd.ld_length) begin
                r_held_length <= i_rx_byte[4:0];
                r_byte_count  <= 5'd0;
                r_check       <= r_check - i_rx_byte;
            end
            if (i_cmd.wr_byte) begin
                r_byte_count <= r_byte_count + 5'd1;
                r_check      <= r_check - i_rx_byte;
            end
        end
    end

    // Next result index; also the read address, so data lines up with r_idx
    always_comb begin
        if (load_any) begin
            n_idx = 4'd0;
        end else if (out_take && !r_last) begin
            n_idx = r_idx + 4'd1;
        end else begin
            n_idx = r_idx;
        end
    end

    slcd_ram #(
        .WIDTH  (8),
        .DEPTH  (PAYLOAD_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_byte),
        .i_wr_addr (ADDR_W'(r_byte_count)),
        .i_wr_data (i_rx_byte),
        .i_rd_addr (ADDR_W'(n_idx)),
        .o_rd_data (rd_data)
    );

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_any) begin
            r_out_valid <= 1'b1;
        end else if (out_take && r_last) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.put_len_err) begin
            r_out_opcode <= r_opcode;
            r_out_length <= i_rx_byte;
            r_out_status <= ST_LEN_ERR;
            r_last       <= 1'b1;
            r_from_ram   <= 1'b0;
        end else if (i_cmd.put_sum_err) begin
            r_out_opcode <= r_opcode;
            r_out_length <= {3'b000, r_held_length};
            r_out_status <= ST_SUM_ERR;
            r_last       <= 1'b1;
            r_from_ram   <= 1'b0;
        end else if (i_cmd.put_empty) begin
            r_out_opcode <= r_opcode;
            r_out_length <= 8'd0;
            r_out_status <= ST_OK;
            r_last       <= 1'b1;
            r_from_ram   <= 1'b0;
        end else if (i_cmd.start_emit) begin
            r_out_opcode <= r_opcode;
            r_out_length <= {3'b000, r_held_length};
            r_out_status <= ST_OK;
            r_last       <= (r_held_length == 5'd1);
            r_from_ram   <= 1'b1;
        end else if (out_take && !r_last) begin
            r_last <= (({1'b0, r_idx} + 5'd2) == r_held_length);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_opcode  = r_out_opcode;
    assign o_frame_length  = r_out_length;
    assign o_payload_byte  = r_from_ram ? rd_data : 8'd0;
    assign o_payload_index = r_idx;
    assign o_status        = r_out_status;
    assign o_last          = r_last;

endmodule

FILE: hdl/sync_length_checksum_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Byte-stream deframer: sync byte, opcode, length, payload, checksum.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_rx_byte) takes one received
//   byte per transaction. One byte per cycle is sustained while the output
//   register is free and no payload is being emitted.
//   Output channel (o_out_valid / i_out_ready) carries results. A good frame
//   with payload gives one result per payload byte, index 0 upwards, last set
//   on the final one; an empty frame gives one ok result; a bad length or bad
//   checksum gives one error result with last set.
//   A result appears the cycle after the byte that completes it.
//   Payload bytes then follow one per cycle while the receiver is ready, read
//   from the payload RAM through its registered port; input is held off
//   until the last one is taken.
//   The receiver may stall at any time: the result register holds and input
//   waits while a result is pending and not being taken.
//   Configuration port (i_cfg_valid / o_cfg_ready) is always ready; index 0
//   is the sync value, index 1 the largest payload length; other indexes
//   are dropped.
//   Reset (i_rst_n low, synchronous) returns to sync hunting, empties the
//   result register and restores the register defaults.
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer
    import slcd_pkg::*;
#(
    parameter int PAYLOAD_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // received bytes
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    // results
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_frame_opcode,
    output logic [7:0] o_frame_length,
    output logic [7:0] o_payload_byte,
    output logic [3:0] o_payload_index,
    output logic [1:0] o_status,
    output logic       o_last
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Registers take a write in any cycle
    assign o_cfg_ready = 1'b1;

    // Phase sequencing: decode each byte into commands
    slcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Fields, checksum, payload store and result register
    slcd_datapath #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_rx_byte       (i_rx_byte),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_opcode  (o_frame_opcode),
        .o_frame_length  (o_frame_length),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    // Never take a byte while a pending result is stalled
    a_no_take_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while result stalled");

    // Error results always close the frame
    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> o_last)
        else $error("error result without last");

    // A taken non-final payload result is followed by the next index
    a_emit_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last) |=>
        (o_out_valid && o_payload_index == 4'($past(o_payload_index) + 4'd1)))
        else $error("payload emission skipped or stopped");

    // No new bytes during payload emission
    a_hold_during_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> !o_in_ready)
        else $error("input taken during payload emission");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for sync_length_checksum_deframer
// Drives a received byte stream made of well-formed frames with random
// content, mixed with noise, truncated frames, bad lengths and bad checksums.
// A frame tracker predicts every result from the bytes that the block
// accepts and checks the result stream field by field. The run steps
// through several sync values and length limits, with random idling on
// both sides, one long receiver hold-off and one stretch with no idling.
// ----------------------------------------------------------------------------
import slcd_pkg::*;

typedef enum logic [2:0] {
    HUNT_SYNC,
    TAKE_OPCODE,
    TAKE_LENGTH,
    TAKE_PAYLOAD,
    TAKE_CHECK
} t_rx_phase;

typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] length;
    logic [7:0] data;
    logic [3:0] index;
    logic [1:0] status;
    logic       is_last;
} t_frame_result;

class frame_result_tracker;
    localparam int STORE_DEPTH = 16;

    // register copies
    logic [7:0]    sync_byte;
    logic [4:0]    len_limit_reg;
    // frame state
    t_rx_phase     ph;
    logic [7:0]    opc;
    logic [4:0]    held_len;
    logic [4:0]    count;
    logic [7:0]    chk;
    logic [7:0]    store [STORE_DEPTH];
    // results still owed by the block, oldest first
    t_frame_result owed_results [$];
    int            n_mismatch;
    int            n_checked;
    int            n_good;
    int            n_len_err;
    int            n_sum_err;

    function new();
        sync_byte     = SYNC_RESET;
        len_limit_reg = MAXLEN_RESET;
        ph            = HUNT_SYNC;
        opc           = '0;
        held_len      = '0;
        count         = '0;
        chk           = 8'hFF;
        n_mismatch    = 0;
        n_checked     = 0;
        n_good        = 0;
        n_len_err     = 0;
        n_sum_err     = 0;
    endfunction

    // Clip the register to the payload store and the per-frame result bound
    function int limit();
        int lim;
        lim = len_limit_reg;
        if (lim > STORE_DEPTH) lim = STORE_DEPTH;
        if (lim > MAX_RESULTS) lim = MAX_RESULTS;
        return lim;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] val);
        if (idx == CFG_SYNC_VALUE) sync_byte = val;
        else if (idx == CFG_MAX_LENGTH) len_limit_reg = val[4:0];
    endfunction

    function void owe(logic [7:0] data, logic [3:0] index, logic [1:0] st, logic lst,
                      logic [7:0] len);
        t_frame_result r;
        r.opcode  = opc;
        r.length  = len;
        r.data    = data;
        r.index   = index;
        r.status  = st;
        r.is_last = lst;
        owed_results.push_back(r);
    endfunction

    // Advance the frame state by one accepted byte
    function void note_byte(logic [7:0] b);
        case (ph)
            HUNT_SYNC: begin
                if (b == sync_byte) begin
                    chk = 8'hFF - b;
                    ph  = TAKE_OPCODE;
                end
            end
            TAKE_OPCODE: begin
                opc = b;
                chk = chk - b;
                ph  = TAKE_LENGTH;
            end
            TAKE_LENGTH: begin
                chk = chk - b;
                if (int'(b) > limit()) begin
                    owe(8'h00, 4'h0, ST_LEN_ERR, 1'b1, b);
                    n_len_err++;
                    ph = HUNT_SYNC;
                end else begin
                    held_len = b[4:0];
                    count    = '0;
                    ph       = (b == 8'h00) ? TAKE_CHECK : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD: begin
                if (count < STORE_DEPTH) store[count[3:0]] = b;
                chk   = chk - b;
                count = count + 5'd1;
                if (count >= held_len) ph = TAKE_CHECK;
            end
            TAKE_CHECK: begin
                if (b != chk) begin
                    owe(8'h00, 4'h0, ST_SUM_ERR, 1'b1, {3'b000, held_len});
                    n_sum_err++;
                end else if (held_len == 5'd0) begin
                    owe(8'h00, 4'h0, ST_OK, 1'b1, 8'h00);
                    n_good++;
                end else begin
                    for (int i = 0; i < int'(held_len); i++)
                        owe(store[i], 4'(i), ST_OK, (i + 1 == int'(held_len)),
                            {3'b000, held_len});
                    n_good++;
                end
                ph = HUNT_SYNC;
            end
            default: ph = HUNT_SYNC;
        endcase
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            n_mismatch++;
        end
    endfunction

    function void check_result(t_frame_result got);
        t_frame_result want;
        if (owed_results.size() == 0) begin
            $error("unexpected result: opcode %0h length %0h status %0h",
                   got.opcode, got.length, got.status);
            n_mismatch++;
            return;
        end
        want = owed_results.pop_front();
        n_checked++;
        cmp_field("frame_opcode", want.opcode, got.opcode);
        cmp_field("frame_length", want.length, got.length);
        cmp_field("payload_byte", want.data, got.data);
        cmp_field("payload_index", {4'h0, want.index}, {4'h0, got.index});
        cmp_field("status", {6'h00, want.status}, {6'h00, got.status});
        cmp_field("last", {7'h00, want.is_last}, {7'h00, got.is_last});
    endfunction
endclass

module tb;

    localparam int         STORE_DEPTH     = 16;
    localparam int         CYCLE_LIMIT     = 200_000;
    localparam int         HOLD_OFF_CYCLES = 80;
    localparam int         IDLE_PERCENT    = 13;
    localparam int         BAD_SUM_PERCENT = 15;
    localparam int         NO_CUT          = -1;
    // indexes outside the register map, written to check they are dropped
    localparam logic [7:0] CFG_UNUSED_LOW  = 8'd2;
    localparam logic [7:0] CFG_UNUSED_HIGH = 8'hFF;

    // Stimulus stages, seen by the receiver to shape its idling
    typedef enum logic [1:0] {
        STG_IDLING,
        STG_HOLD_OFF,
        STG_STEADY
    } t_stage;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_rx_byte;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_frame_opcode;
    logic [7:0] o_frame_length;
    logic [7:0] o_payload_byte;
    logic [3:0] o_payload_index;
    logic [1:0] o_status;
    logic       o_last;

    frame_result_tracker tracker = new();
    t_stage              stage;
    int                  bytes_counted;
    int                  cycle_count;

    sync_length_checksum_deframer #(
        .PAYLOAD_DEPTH(STORE_DEPTH)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_opcode (o_frame_opcode),
        .o_frame_length (o_frame_length),
        .o_payload_byte (o_payload_byte),
        .o_payload_index(o_payload_index),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Byte channel
    // ------------------------------------------------------------------------

    // Offer one byte and hold it until the block takes it. Valid is left high
    // on return so back-to-back bytes never drop it; idle gaps lower it first.
    task automatic send_byte(input logic [7:0] b, input bit counts);
        if (stage != STG_STEADY && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_byte(b);
        if (counts) bytes_counted++;
    endtask

    // Send one frame with the current sync value. A length over the limit
    // stops after the length byte, as the block drops back to hunting; a cut
    // stops the payload early so the next frame lands in the payload.
    task automatic send_frame(input logic [7:0] op, input logic [7:0] len,
                              input bit random_fill, input bit bad_sum, input int cut);
        logic [7:0] sum;
        logic [7:0] b;
        int         lim;
        lim = tracker.limit();
        sum = 8'hFF - tracker.sync_byte;
        send_byte(tracker.sync_byte, 1'b1);
        sum = sum - op;
        send_byte(op, 1'b1);
        sum = sum - len;
        send_byte(len, 1'b1);
        if (int'(len) > lim) return;
        for (int i = 0; i < int'(len); i++) begin
            if (i == cut) return;
            b   = random_fill ? 8'($urandom_range(0, 255)) : ((i % 2) ? 8'hFF : 8'h00);
            sum = sum - b;
            send_byte(b, 1'b1);
        end
        if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum, 1'b1);
    endtask

    // Mostly good frames with random content, short lengths favoured, the
    // limit itself now and then; the rest noise, cut frames, bad lengths and bad checksums.
    task automatic send_random_frame();
        int         lim;
        int         pick;
        int         cut;
        logic [7:0] len;
        lim = tracker.limit();
        if ($urandom_range(0, 99) < 8)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        pick = $urandom_range(0, 99);
        cut  = NO_CUT;
        if (pick < 12) begin
            len = $urandom_range(0, 1) ? 8'(lim + 1) : 8'($urandom_range(lim + 1, 255));
        end else begin
            len = ($urandom_range(0, 7) == 0) ? 8'(lim)
                                              : 8'($urandom_range(0, (lim < 6) ? lim : 6));
            if (pick < 17 && len != 8'h00) cut = $urandom_range(0, int'(len) - 1);
        end
        send_frame(8'($urandom_range(0, 255)), len, 1'b1,
                   $urandom_range(0, 99) < BAD_SUM_PERCENT, cut);
    endtask

    task automatic send_random(input int n);
        int target;
        target = bytes_counted + n;
        while (bytes_counted < target) send_random_frame();
    endtask

    // Hold the input until every owed result is out, then let the block settle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (tracker.owed_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Register channel
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.write_reg(idx, data);
    endtask

    // Upper data bits of the limit register are junk and must be dropped
    task automatic apply_settings(input logic [7:0] sync, input logic [4:0] max_len);
        write_reg(CFG_SYNC_VALUE, sync);
        write_reg(CFG_MAX_LENGTH, {3'($urandom_range(0, 7)), max_len});
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: check every accepted transaction, then choose the next
    // ready. One long hold-off is counted here, so the block fills up and
    // stalls its input while the sender keeps offering bytes.
    // ------------------------------------------------------------------------
    initial begin : result_side
        int            hold_left;
        bit            hold_done;
        t_frame_result got;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_out_ready && o_out_valid !== 1'b0) begin
                got.opcode  = o_frame_opcode;
                got.length  = o_frame_length;
                got.data    = o_payload_byte;
                got.index   = o_payload_index;
                got.status  = o_status;
                got.is_last = o_last;
                tracker.check_result(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stage == STG_HOLD_OFF && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
                i_out_ready <= 1'b0;
            end else if (stage == STG_STEADY || !i_rst_n) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Watchdog: end the run if the stream stops moving
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : byte_side
        bytes_counted = 0;
        stage        <= STG_IDLING;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_rx_byte    <= 8'h00;
        i_cfg_valid  <= 1'b0;
        i_cfg_index  <= 8'h00;
        i_cfg_data   <= 8'h00;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset settings: noise while hunting, empty frames with
        // good and bad checksum, lengths far and just over the limit, and
        // short frames carrying all-zero and all-one bytes.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_frame(8'h00, 8'd0, 1'b0, 1'b0, NO_CUT);
        send_frame(8'hFF, 8'd0, 1'b0, 1'b1, NO_CUT);
        send_frame(8'h5A, 8'd255, 1'b0, 1'b0, NO_CUT);
        send_frame(8'hA5, 8'd17, 1'b0, 1'b0, NO_CUT);
        send_frame(8'h3C, 8'd2, 1'b0, 1'b0, NO_CUT);
        send_frame(8'hC3, 8'd1, 1'b0, 1'b1, NO_CUT);

        send_random(30);

        // Zero limit: only empty frames get through, sync of all zeros
        drain_results();
        apply_settings(8'h00, 5'd0);
        send_random(15);

        // Register above the store behaves as a full store; fill the block
        // with a full frame while the receiver holds off
        drain_results();
        apply_settings(8'hFF, 5'd31);
        stage <= STG_HOLD_OFF;
        send_frame(8'($urandom_range(0, 255)), 8'd16, 1'b1, 1'b0, NO_CUT);
        send_random_frame();
        send_random_frame();
        stage <= STG_IDLING;
        send_random(20);

        // Dropped indexes, then a stretch with no idling on either side
        drain_results();
        write_reg(CFG_UNUSED_LOW, 8'($urandom_range(0, 255)));
        write_reg(CFG_UNUSED_HIGH, 8'($urandom_range(0, 255)));
        apply_settings(8'($urandom_range(0, 255)), 5'd17);
        stage <= STG_STEADY;
        send_random(20);

        drain_results();
        stage <= STG_IDLING;
        apply_settings(SYNC_RESET, 5'd3);
        send_random(15);

        drain_results();
        apply_settings(8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        send_random(20);

        // Wind down: wait out every owed result plus the block's latency
        i_in_valid <= 1'b0;
        while (tracker.owed_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d frame bytes: %0d good frames, %0d length errors, %0d checksum errors",
                 bytes_counted, tracker.n_good, tracker.n_len_err, tracker.n_sum_err);
        $display("Checked %0d results in %0d cycles", tracker.n_checked, cycle_count);
        if (tracker.n_mismatch == 0 && tracker.owed_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/slcd_pkg.sv
hdl/slcd_ram.sv
hdl/slcd_ctrl.sv
hdl/slcd_datapath.sv
hdl/sync_length_checksum_deframer.sv
tb/tb.sv
